// ----- hw/rtl/sfpd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfpd_pkg
// Shared types and constants for the serial frame PWM duty setter.
// ----------------------------------------------------------------------------
package sfpd_pkg;

    localparam logic [7:0]  SYNC_FIRST           = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND          = 8'h55;
    localparam logic [15:0] FULL_SCALE           = 16'hFFFF;
    localparam logic [15:0] PERIOD_RESET         = 16'd38001;
    localparam int          NUM_CHANNELS_DEFAULT = 4;

    // Frame parser phase
    typedef enum logic [2:0] {
        PH_SYNC_FIRST  = 3'd0,
        PH_SYNC_SECOND = 3'd1,
        PH_CHANNEL     = 3'd2,
        PH_DUTY_HIGH   = 3'd3,
        PH_DUTY_LOW    = 3'd4
    } phase_t;

    // Completed frame handed from the parser to the scaler
    typedef struct packed {
        logic        done;
        logic        ok;
        logic [7:0]  channel;
        logic [15:0] duty;
    } frame_t;

endpackage

// ----- hw/rtl/serial_frame_pwm_duty_setter.sv -----
// ----------------------------------------------------------------------------
// serial_frame_pwm_duty_setter: last byte -> product register -> result register
// Throughput: one byte per cycle while the result side does not stall.
// Reset (rst_n async low) empties all stages, parser waits for 0xAA, period 38001.
// ----------------------------------------------------------------------------
module serial_frame_pwm_duty_setter
    import sfpd_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Received byte channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        rx_error,
    // Result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  channel,
    output logic [15:0] duty_code,
    output logic [15:0] compare_value,
    output logic        accepted,
    // Period register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] pwm_period
);

    // Input register: one byte of the serial stream
    logic        byte_valid_reg;
    logic [7:0]  byte_data_reg;
    logic        byte_error_reg;

    logic [15:0] period_reg;
    logic        frame_ready;
    logic        byte_take;
    frame_t      frame;

    // Period register: writes are always accepted (cfg_ready tied high)
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            period_reg <= pwm_period;
        end
    end

    // Hold the input byte only while it cannot move on to the parser; any
    // byte, framed or not, leaves the input register when the product stage
    // has room, so stalls on the result side reach here only once full.
    assign byte_take = byte_valid_reg && frame_ready;
    assign in_stall  = byte_valid_reg && !frame_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            byte_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_data_reg  <= rx_byte;
            byte_error_reg <= rx_error;
        end
    end

    // Parse: advance the frame state on each good byte, flag the last one
    sfpd_frame_parser #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_take),
        .byte_data  (byte_data_reg),
        .byte_error (byte_error_reg),
        .frame      (frame)
    );

    // Scale: multiply by the period, divide by full scale, store and report
    sfpd_duty_scaler #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_scaler (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame         (frame),
        .period        (period_reg),
        .frame_ready   (frame_ready),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .channel       (channel),
        .duty_code     (duty_code),
        .compare_value (compare_value),
        .accepted      (accepted)
    );

endmodule

// ----- hw/rtl/sfpd_frame_parser.sv -----
// ----------------------------------------------------------------------------
// sfpd_frame_parser
// Byte-wise parser for AA 55 channel duty_hi duty_lo frames.
// ----------------------------------------------------------------------------
module sfpd_frame_parser
    import sfpd_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    input  logic       byte_error,
    output frame_t     frame
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] channel_reg;
    logic [7:0] channel_next;
    logic [7:0] duty_high_reg;
    logic [7:0] duty_high_next;
    logic       take;

    // Errored bytes are dropped without touching any state
    assign take = byte_valid && !byte_error;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SYNC_FIRST;
            channel_reg   <= '0;
            duty_high_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            channel_reg   <= channel_next;
            duty_high_reg <= duty_high_next;
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            case (phase_reg)
                PH_SYNC_FIRST:
                    phase_next = (byte_data == SYNC_FIRST) ? PH_SYNC_SECOND : PH_SYNC_FIRST;
                PH_SYNC_SECOND:
                    phase_next = (byte_data == SYNC_SECOND) ? PH_CHANNEL : PH_SYNC_FIRST;
                PH_CHANNEL:
                    phase_next = PH_DUTY_HIGH;
                PH_DUTY_HIGH:
                    phase_next = PH_DUTY_LOW;
                PH_DUTY_LOW:
                    phase_next = PH_SYNC_FIRST;
                default:
                    phase_next = (byte_data == SYNC_FIRST) ? PH_SYNC_SECOND : PH_SYNC_FIRST;
            endcase
        end
    end

    // Held fields and frame output
    always_comb
    begin
        channel_next   = channel_reg;
        duty_high_next = duty_high_reg;
        frame.done     = 1'b0;
        frame.channel  = channel_reg;
        frame.duty     = {duty_high_reg, byte_data};
        frame.ok       = (channel_reg != 8'd0) && (channel_reg <= 8'(NUM_CHANNELS));
        if (take)
        begin
            case (phase_reg)
                PH_CHANNEL:   channel_next   = byte_data;
                PH_DUTY_HIGH: duty_high_next = byte_data;
                PH_DUTY_LOW:  frame.done     = 1'b1;
                default:      ;
            endcase
        end
    end

endmodule

// ----- hw/rtl/sfpd_duty_scaler.sv -----
// ----------------------------------------------------------------------------
// sfpd_duty_scaler
// Product stage, divide by full scale, compare registers and result register.
// ----------------------------------------------------------------------------
module sfpd_duty_scaler
    import sfpd_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  frame_t      frame,
    input  logic [15:0] period,
    output logic        frame_ready,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  channel,
    output logic [15:0] duty_code,
    output logic [15:0] compare_value,
    output logic        accepted
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic        prod_valid_reg;
    logic        prod_ok_reg;
    logic [7:0]  prod_channel_reg;
    logic [15:0] prod_duty_reg;
    logic [31:0] prod_reg;

    logic        out_valid_reg;
    logic        out_ok_reg;
    logic [7:0]  out_channel_reg;
    logic [15:0] out_duty_reg;
    logic [15:0] out_compare_reg;

    logic [15:0] compare_reg [NUM_CHANNELS];

    logic        out_free;
    logic        prod_move;
    logic [15:0] quot_low;
    logic [16:0] rem;
    logic [15:0] quot;
    logic [7:0]  slot;

    assign out_free    = !out_valid_reg || !out_stall;
    assign frame_ready = !prod_valid_reg || out_free;
    assign prod_move   = prod_valid_reg && out_free;

    // x / 65535: take x >> 16, the remainder is low half plus that estimate
    // and stays below twice the divisor, so one correction step suffices
    assign quot_low = prod_reg[31:16];
    assign rem      = {1'b0, prod_reg[15:0]} + {1'b0, quot_low};
    assign quot     = (rem >= {1'b0, FULL_SCALE}) ? quot_low + 16'd1 : quot_low;
    assign slot     = prod_channel_reg - 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (frame_ready)
            begin
                prod_valid_reg <= frame.done;
            end
            if (out_free)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_ready && frame.done)
        begin
            prod_ok_reg      <= frame.ok;
            prod_channel_reg <= frame.channel;
            prod_duty_reg    <= frame.duty;
            prod_reg         <= period * frame.duty;
        end
        if (prod_move)
        begin
            out_ok_reg      <= prod_ok_reg;
            out_channel_reg <= prod_channel_reg;
            out_duty_reg    <= prod_duty_reg;
            out_compare_reg <= quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                compare_reg[i] <= '0;
            end
        end
        else if (prod_move && prod_ok_reg)
        begin
            compare_reg[slot[IDX_W-1:0]] <= quot;
        end
    end

    assign out_valid     = out_valid_reg;
    assign channel       = out_channel_reg;
    assign duty_code     = out_duty_reg;
    assign compare_value = out_compare_reg;
    assign accepted      = out_ok_reg;

`ifndef SYNTHESIS
    a_quot_floor: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg |-> ({16'd0, quot} * 32'd65535) <= prod_reg)
        else $error("quotient above floor");

    a_quot_tight: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg |-> (prod_reg - {16'd0, quot} * 32'd65535) < 32'd65535)
        else $error("quotient below floor");

    a_accept_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ok_reg) |->
            (out_channel_reg != 8'd0) && (out_channel_reg <= 8'(NUM_CHANNELS)))
        else $error("accepted frame with channel out of range");

    a_cmp_le_duty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_compare_reg <= out_duty_reg)
        else $error("compare value exceeds duty code");
`endif

endmodule
